// File: hw/rtl/assert_macros.svh
// assertion macros, empty in synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// File: hw/rtl/cdsf_pkg.sv
`timescale 1ns / 1ps
package cdsf_pkg;
  localparam int MAX_ENTRIES_DEF = 64;
  localparam int MAX_POINTS_DEF = 256;
  localparam int COEFF_BITS_DEF = 16;
  localparam int SUM_W = 24;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic [2:0] ST_ADDED = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_DOMINATED = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_CLEARED = 3'd4;
  localparam logic [2:0] ST_READ = 3'd5;

  typedef struct packed {
    logic [1:0] command;
    logic [15:0] coefficient;
    logic [15:0] tag;
    logic [5:0] entry_index;
    logic [1:0] word_index;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [6:0] kept_count;
    logic [6:0] removed_count;
    logic [15:0] read_tag;
    logic [23:0] read_sum;
    logic [63:0] read_mask_word;
  } rsp_t;
endpackage

// File: hw/rtl/cdsf_req_if.sv
`timescale 1ns / 1ps
interface cdsf_req_if;
  logic valid;
  logic ready;
  logic [1:0] command;
  logic [15:0] coefficient;
  logic [15:0] tag;
  logic [5:0] entry_index;
  logic [1:0] word_index;
  modport source (output valid, command, coefficient, tag, entry_index, word_index,
                  input ready);
  modport sink (input valid, command, coefficient, tag, entry_index, word_index,
                output ready);
endinterface

// File: hw/rtl/cdsf_rsp_if.sv
`timescale 1ns / 1ps
interface cdsf_rsp_if;
  logic valid;
  logic ready;
  logic [2:0] status;
  logic [6:0] kept_count;
  logic [6:0] removed_count;
  logic [15:0] read_tag;
  logic [23:0] read_sum;
  logic [63:0] read_mask_word;
  modport source (output valid, status, kept_count, removed_count, read_tag, read_sum,
                  read_mask_word, input ready);
  modport sink (input valid, status, kept_count, removed_count, read_tag, read_sum,
                read_mask_word, output ready);
endinterface

// File: hw/rtl/cdsf_ram.sv
`timescale 1ns / 1ps
module cdsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: hw/rtl/cdsf_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// candidate accumulation and set walk over the entry memories
module cdsf_ctrl #(
  parameter int MAX_ENTRIES = cdsf_pkg::MAX_ENTRIES_DEF,
  parameter int MAX_POINTS = cdsf_pkg::MAX_POINTS_DEF,
  parameter int COEFF_BITS = cdsf_pkg::COEFF_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [8:0]       point_count,
  input  logic             in_valid,
  output logic             in_ready,
  input  cdsf_pkg::req_t   req,
  output logic             out_valid,
  input  logic             out_ready,
  output cdsf_pkg::rsp_t   rsp
);
  localparam int WORDS = (MAX_POINTS + 63) / 64;
  localparam int WB = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int EB = $clog2(MAX_ENTRIES);
  localparam int CB = $clog2(MAX_ENTRIES + 1);
  localparam int PB = $clog2(MAX_POINTS + 1);
  localparam int MB = EB + WB;
  localparam int SW = cdsf_pkg::SUM_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMP = 3'd1;   // read entry words
  localparam logic [2:0] S_MV = 3'd2;    // copy last entry down
  localparam logic [2:0] S_APP = 3'd3;   // write candidate
  localparam logic [2:0] S_RD = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;

  logic [2:0] state;
  logic [63:0] cmask [WORDS];
  logic [SW-1:0] csum;
  logic [15:0] ctag;
  logic [PB-1:0] ecnt;
  logic [CB-1:0] count;
  logic [CB-1:0] idx;
  logic [6:0] removed;
  logic [WB:0] wcnt;
  logic e_only, c_only, pending;
  logic rd_ok;
  cdsf_pkg::rsp_t res;

  // memory ports
  logic t_we, s_we, m_we;
  logic [EB-1:0] ts_waddr, ts_raddr;
  logic [15:0] t_wdata, t_rdata;
  logic [SW-1:0] s_wdata, s_rdata;
  logic [MB-1:0] m_waddr, m_raddr;
  logic [63:0] m_wdata, m_rdata;

  cdsf_ram #(.WIDTH(16), .DEPTH(MAX_ENTRIES)) u_tags (
    .clk, .we(t_we), .waddr(ts_waddr), .wdata(t_wdata), .raddr(ts_raddr), .rdata(t_rdata));
  cdsf_ram #(.WIDTH(SW), .DEPTH(MAX_ENTRIES)) u_sums (
    .clk, .we(s_we), .waddr(ts_waddr), .wdata(s_wdata), .raddr(ts_raddr), .rdata(s_rdata));
  cdsf_ram #(.WIDTH(64), .DEPTH(MAX_ENTRIES * (1 << WB))) u_masks (
    .clk, .we(m_we), .waddr(m_waddr), .wdata(m_wdata), .raddr(m_raddr), .rdata(m_rdata));

  logic [PB-1:0] eff_points;
  always_comb begin
    if (point_count == 9'd0) eff_points = PB'(1);
    else if ({23'd0, point_count} > 32'(MAX_POINTS)) eff_points = PB'(MAX_POINTS);
    else eff_points = PB'(point_count);
  end

  logic [COEFF_BITS-1:0] coeff;
  assign coeff = COEFF_BITS'(req.coefficient);
  logic [SW:0] sum_add;
  logic [SW-1:0] sum_base;
  assign sum_base = (ecnt == '0) ? '0 : csum;
  assign sum_add = {1'b0, sum_base} + (SW+1)'(coeff);

  // mask after this push, cleared on the first coefficient
  logic [63:0] cmask_next [WORDS];
  always_comb begin
    for (int w = 0; w < WORDS; w++) cmask_next[w] = (ecnt == '0) ? 64'd0 : cmask[w];
    if (coeff != '0) cmask_next[ecnt[6+WB-1:6]][ecnt[5:0]] = 1'b1;
  end

  logic [CB-1:0] last;
  assign last = count - CB'(1);
  logic [WB-1:0] wsel;
  assign wsel = wcnt[WB-1:0];
  logic [EB-1:0] idx_e, last_e;
  assign idx_e = idx[EB-1:0];
  assign last_e = last[EB-1:0];

  logic any_bit;
  always_comb begin
    any_bit = 1'b0;
    for (int w = 0; w < WORDS; w++) any_bit |= (cmask[w] != 64'd0);
  end

  // word currently returned by the mask memory (its address was issued in the cycle before)
  logic [WB:0] wprev;
  logic eo_w, co_w;
  assign eo_w = (m_rdata & ~cmask[wprev[WB-1:0]]) != 64'd0;
  assign co_w = (cmask[wprev[WB-1:0]] & ~m_rdata) != 64'd0;
  logic eo_f, co_f;
  assign eo_f = e_only | eo_w;
  assign co_f = c_only | co_w;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign rsp = res;

  function automatic cdsf_pkg::rsp_t make_rsp(input logic [2:0] st, input logic [6:0] kept,
                                              input logic [6:0] rem);
    make_rsp = '{status: st, kept_count: kept, removed_count: rem, read_tag: 16'd0,
                 read_sum: 24'd0, read_mask_word: 64'd0};
  endfunction

  always_comb begin
    t_we = 1'b0; s_we = 1'b0; m_we = 1'b0;
    ts_waddr = idx_e; ts_raddr = idx_e;
    t_wdata = t_rdata; s_wdata = s_rdata;
    m_waddr = {idx_e, wsel}; m_raddr = {idx_e, wsel}; m_wdata = m_rdata;
    case (state)
      S_IDLE: begin
        ts_raddr = req.entry_index[EB-1:0];
        m_raddr = {req.entry_index[EB-1:0], req.word_index[WB-1:0]};
      end
      S_CMP: begin
        ts_raddr = idx_e;
        m_raddr = {idx_e, wsel};
      end
      S_MV: begin
        // read last entry word, write previous word into idx slot
        ts_raddr = last_e;
        m_raddr = {last_e, wsel};
        m_waddr = {idx_e, wprev[WB-1:0]};
        m_we = pending;
        t_we = pending && (wprev == '0);
        s_we = t_we;
      end
      S_APP: begin
        m_waddr = {idx_e, wsel};
        m_wdata = cmask[wsel];
        m_we = 1'b1;
        t_we = (wcnt == '0);
        s_we = t_we;
        t_wdata = ctag;
        s_wdata = csum;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ecnt <= '0;
      count <= '0;
      csum <= '0;
      ctag <= '0;
      for (int w = 0; w < WORDS; w++) cmask[w] <= 64'd0;
      pending <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (req.command)
              cdsf_pkg::CMD_PUSH: begin
                if (ecnt == '0) ctag <= req.tag;
                for (int w = 0; w < WORDS; w++) cmask[w] <= cmask_next[w];
                csum <= sum_add[SW] ? cdsf_pkg::SUM_MAX : sum_add[SW-1:0];
                if (ecnt + PB'(1) >= eff_points) begin
                  ecnt <= '0;
                  idx <= '0;
                  removed <= '0;
                  wcnt <= '0;
                  e_only <= 1'b0;
                  c_only <= 1'b0;
                  pending <= 1'b0;
                  state <= S_CMP;
                end else begin
                  ecnt <= ecnt + PB'(1);
                end
              end
              cdsf_pkg::CMD_CLEAR: begin
                count <= '0;
                ecnt <= '0;
                res <= make_rsp(cdsf_pkg::ST_CLEARED, 7'd0, 7'd0);
                state <= S_OUT;
              end
              cdsf_pkg::CMD_READ: begin
                rd_ok <= ({1'b0, req.entry_index} < 7'(count))
                         && (32'(req.word_index) < WORDS)
                         && (32'(req.entry_index) < MAX_ENTRIES);
                state <= S_RD;
              end
              default: ;
            endcase
          end
        end
        S_CMP: begin
          // walk: issue word wcnt, evaluate word wprev
          if (!any_bit) begin
            res <= make_rsp(cdsf_pkg::ST_EMPTY, 7'(count), 7'd0);
            state <= S_OUT;
          end else if (idx >= count) begin
            if (count >= CB'(MAX_ENTRIES)) begin
              res <= make_rsp(cdsf_pkg::ST_FULL, 7'(count), removed);
              state <= S_OUT;
            end else begin
              wcnt <= '0;
              state <= S_APP;
            end
          end else if (!pending) begin
            pending <= 1'b1;
            wprev <= wcnt;
            wcnt <= wcnt + 1'b1;
          end else begin
            if (32'(wprev) + 1 < WORDS) begin
              e_only <= eo_f;
              c_only <= co_f;
              wprev <= wcnt;
              wcnt <= wcnt + 1'b1;
            end else begin
              pending <= 1'b0;
              wcnt <= '0;
              e_only <= 1'b0;
              c_only <= 1'b0;
              if ((eo_f && !co_f) || (!eo_f && !co_f && s_rdata >= csum)) begin
                res <= make_rsp(cdsf_pkg::ST_DOMINATED, 7'(count), removed);
                state <= S_OUT;
              end else if (!eo_f && co_f || !eo_f && !co_f) begin
                removed <= removed + 7'd1;
                if (idx == last) begin
                  count <= last;
                end else begin
                  state <= S_MV;
                end
              end else begin
                idx <= idx + CB'(1);
              end
            end
          end
        end
        S_MV: begin
          if (!pending) begin
            pending <= 1'b1;
            wprev <= wcnt;
            wcnt <= wcnt + 1'b1;
          end else if (32'(wprev) + 1 < WORDS) begin
            wprev <= wcnt;
            wcnt <= wcnt + 1'b1;
          end else begin
            pending <= 1'b0;
            wcnt <= '0;
            count <= last;
            state <= S_CMP;
          end
        end
        S_APP: begin
          if (32'(wcnt) + 1 < WORDS) begin
            wcnt <= wcnt + 1'b1;
          end else begin
            count <= count + CB'(1);
            res <= make_rsp(cdsf_pkg::ST_ADDED, 7'(count + CB'(1)), removed);
            state <= S_OUT;
          end
        end
        S_RD: begin
          res <= '{status: cdsf_pkg::ST_READ, kept_count: 7'(count), removed_count: 7'd0,
                   read_tag: rd_ok ? t_rdata : 16'd0,
                   read_sum: rd_ok ? s_rdata : 24'd0,
                   read_mask_word: rd_ok ? m_rdata : 64'd0};
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_count_range, clk, rst, count <= CB'(MAX_ENTRIES), "entry count overflow")
  `ASSERT_CLK(a_one_side, clk, rst, !(in_ready && out_valid), "busy and idle at once")
  `ASSERT_CLK(a_walk_bound, clk, rst, (state == S_MV) |-> (idx < count), "move past last entry")
endmodule

// File: hw/rtl/coverage_dominance_set_filter.sv
`timescale 1ns / 1ps
// Keeps a set of mutually non-dominated coverage vectors in tag, sum and mask
// memories. The closing push walks the set, reading one mask word per cycle from
// the mask RAM for each entry compared, copying the last entry down for each
// removal and writing the candidate's words to append it.
// The result is held until taken; no request is accepted while one is in work.
module coverage_dominance_set_filter #(
  parameter int MAX_ENTRIES = cdsf_pkg::MAX_ENTRIES_DEF,
  parameter int MAX_POINTS = cdsf_pkg::MAX_POINTS_DEF,
  parameter int COEFF_BITS = cdsf_pkg::COEFF_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [8:0] cfg_wdata,
  cdsf_req_if.sink   req,
  cdsf_rsp_if.source rsp
);
  logic [8:0] point_count;
  always_ff @(posedge clk) begin
    if (rst) point_count <= 9'd256;
    else if (cfg_we) point_count <= cfg_wdata;
  end

  cdsf_pkg::req_t r;
  cdsf_pkg::rsp_t o;
  assign r = '{command: req.command, coefficient: req.coefficient, tag: req.tag,
               entry_index: req.entry_index, word_index: req.word_index};

  cdsf_ctrl #(.MAX_ENTRIES(MAX_ENTRIES), .MAX_POINTS(MAX_POINTS),
              .COEFF_BITS(COEFF_BITS)) u_ctrl (
    .clk, .rst, .point_count,
    .in_valid(req.valid), .in_ready(req.ready), .req(r),
    .out_valid(rsp.valid), .out_ready(rsp.ready), .rsp(o));

  assign rsp.status = o.status;
  assign rsp.kept_count = o.kept_count;
  assign rsp.removed_count = o.removed_count;
  assign rsp.read_tag = o.read_tag;
  assign rsp.read_sum = o.read_sum;
  assign rsp.read_mask_word = o.read_mask_word;
endmodule
